// File: hdl/qlfs_pkg.sv
`default_nettype none

package qlfs_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] MAX_LEVEL_RST = 16'hFFFF;
	localparam logic [23:0] WAIT_SAT = 24'hFFFFFF;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_PUSH = 2'd1,
		ACT_SET  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_DIM  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0]        wait_time;
		logic [15:0]        target_level;
		logic signed [23:0] fall_rate;
		logic               restore_full;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic [QFW-1:0] fill_nx;
		logic           full;
		logic           empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hdl/qlfs_cmd_queue.sv
`default_nettype none

module qlfs_cmd_queue import qlfs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_ctrl_t ctrl,
	input  wire cmd_t    wr_cmd,
	output cmd_t         head_cmd,
	output q_stat_t      stat
);

	localparam int SW = QIW + 1;

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QIW-1:0] head_q;
	logic [QFW-1:0] fill_q;
	logic [SW-1:0]  wr_sum;
	logic [QIW-1:0] wr_idx;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (fill_q == QFW'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

	assign do_push = ctrl.push && !stat.full;
	assign do_pop  = ctrl.pop && !stat.empty;

	assign stat.fill_nx = fill_q + QFW'(do_push) - QFW'(do_pop);

	// tail slot, wrapped once
	always_comb begin
		wr_sum = SW'(head_q) + SW'(fill_q);
		if (wr_sum >= SW'(QUEUE_DEPTH)) begin
			wr_sum = wr_sum - SW'(QUEUE_DEPTH);
		end
		wr_idx = wr_sum[QIW-1:0];
	end

	assign head_cmd = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_idx] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			fill_q <= stat.fill_nx;
			if (do_pop) begin
				if (head_q == QIW'(QUEUE_DEPTH - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + QIW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/queued_light_fade_sequencer.sv
`default_nettype none

// Light fade sequencer. Each transaction on the cmd channel is a tick, a push of a fade
// command into an eight-entry queue, or a direct level load, and gives exactly one
// transaction on the res channel carrying level, phase, queue count and the drop flag.
// One transaction is taken every clock while cmd_stall is low (a stalled result on the
// res port raises it); it passes the input register, then the result register, the path
// between them being one 24x17 multiply followed by the level subtract and clamp.
// max_level may only be written while no transaction is in flight.

module queued_light_fade_sequencer import qlfs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               max_level_we,
	input  wire logic [15:0]        max_level_wdata,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         action,
	input  wire logic [15:0]        elapsed_time,
	input  wire logic [15:0]        wait_time,
	input  wire logic [15:0]        target_level,
	input  wire logic signed [23:0] fall_rate,
	input  wire logic               restore_full,
	input  wire logic [15:0]        new_level,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [15:0]             level,
	output logic [1:0]              phase,
	output logic [3:0]              queue_count,
	output logic                    dropped
);

	logic               v_s1;
	logic [1:0]         action_s1;
	logic [15:0]        elapsed_s1;
	cmd_t               cmd_s1;
	logic [15:0]        new_level_s1;

	logic               v_s2;
	logic [15:0]        level_s2;
	logic [1:0]         phase_s2;
	logic [3:0]         count_s2;
	logic               dropped_s2;

	phase_t             phase_q, phase_d;
	logic [23:0]        waited_q, waited_d;
	logic [15:0]        level_q, level_d;
	logic [15:0]        max_level_q;

	logic               move;
	logic               push_c, pop_c, dropped_c;
	q_ctrl_t            q_ctrl;
	q_stat_t            q_stat;
	cmd_t               head;

	logic [24:0]        wait_sum;
	logic [23:0]        wait_sat;
	logic signed [40:0] prod;
	logic signed [32:0] dec;
	logic signed [33:0] lv;
	logic [15:0]        lv_clamp;

	assign move      = v_s1 && (!v_s2 || !res_stall);
	assign cmd_stall = v_s1 && !move;

	assign q_ctrl.push = push_c && move;
	assign q_ctrl.pop  = pop_c && move;

	qlfs_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_cmd   (cmd_s1),
		.head_cmd (head),
		.stat     (q_stat)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			action_s1           <= action;
			elapsed_s1          <= elapsed_time;
			cmd_s1.wait_time    <= wait_time;
			cmd_s1.target_level <= target_level;
			cmd_s1.fall_rate    <= fall_rate;
			cmd_s1.restore_full <= restore_full;
			new_level_s1        <= new_level;
		end
	end

	// wait timer, saturating
	always_comb begin
		wait_sum = 25'(waited_q) + 25'(elapsed_s1);
		wait_sat = wait_sum[24] ? WAIT_SAT : wait_sum[23:0];
	end

	// dimming step: floor(rate*dt/256), clamp to 0..max
	always_comb begin
		prod = head.fall_rate * $signed({1'b0, elapsed_s1});
		dec  = prod[40:8];
		lv   = $signed({18'd0, level_q}) - 34'(dec);
		if (lv < 0) begin
			lv_clamp = '0;
		end else if (lv > $signed({18'd0, max_level_q})) begin
			lv_clamp = max_level_q;
		end else begin
			lv_clamp = lv[15:0];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		waited_d  = waited_q;
		level_d   = level_q;
		push_c    = 1'b0;
		pop_c     = 1'b0;
		dropped_c = 1'b0;
		unique case (action_s1)
			ACT_TICK: begin
				unique case (phase_q)
					PH_WAIT: begin
						if (q_stat.empty) begin
							phase_d  = PH_IDLE;
							waited_d = '0;
						end else if (wait_sat > {8'd0, head.wait_time}) begin
							waited_d = '0;
							level_d  = max_level_q;
							phase_d  = PH_DIM;
						end else begin
							waited_d = wait_sat;
						end
					end
					PH_DIM: begin
						if (q_stat.empty) begin
							phase_d  = PH_IDLE;
							waited_d = '0;
						end else begin
							level_d = lv_clamp;
							if (lv_clamp <= head.target_level || head.fall_rate < 0) begin
								if (head.restore_full) begin
									level_d = max_level_q;
								end
								pop_c   = 1'b1;
								phase_d = PH_IDLE;
							end
						end
					end
					default: begin
						phase_d = q_stat.empty ? PH_IDLE : PH_WAIT;
					end
				endcase
			end
			ACT_PUSH: begin
				if (q_stat.full) begin
					dropped_c = 1'b1;
				end else begin
					push_c = 1'b1;
				end
			end
			ACT_SET: begin
				level_d = (new_level_s1 > max_level_q) ? max_level_q : new_level_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			waited_q <= '0;
			level_q  <= MAX_LEVEL_RST;
		end else if (move) begin
			phase_q  <= phase_d;
			waited_q <= waited_d;
			level_q  <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= MAX_LEVEL_RST;
		end else if (max_level_we) begin
			max_level_q <= max_level_wdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (move) begin
			v_s2 <= 1'b1;
		end else if (!res_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			level_s2   <= level_d;
			phase_s2   <= phase_d;
			count_s2   <= 4'(q_stat.fill_nx);
			dropped_s2 <= dropped_c;
		end
	end

	assign res_valid   = v_s2;
	assign level       = level_s2;
	assign phase       = phase_s2;
	assign queue_count = count_s2;
	assign dropped     = dropped_s2;

endmodule

`default_nettype wire

// File: hdl/qlfs_checker.sv
`default_nettype none

module qlfs_checker import qlfs_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [15:0] level,
	input wire logic [1:0]  phase,
	input wire logic [3:0]  queue_count,
	input wire logic        dropped
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(level) && $stable(phase)
			&& $stable(queue_count) && $stable(dropped))
		else $error("stalled result changed");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> phase == PH_IDLE || phase == PH_WAIT || phase == PH_DIM)
		else $error("bad phase code");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dropped |-> queue_count == 4'(QUEUE_DEPTH))
		else $error("drop with queue not full");

	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase != PH_IDLE |-> queue_count != 4'd0)
		else $error("active phase with empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> queue_count <= 4'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

bind queued_light_fade_sequencer qlfs_checker u_qlfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.level       (level),
	.phase       (phase),
	.queue_count (queue_count),
	.dropped     (dropped)
);

`default_nettype wire
